FILE: rtl/core/assert_macros.svh
// assertion macros shared by the timer queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define TDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/tdq_pkg.sv
// shared constants, types and helpers of the sorted deadline timer queue
package tdq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TAG_BITS    = 16;

    localparam int ADDR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_BITS  = ADDR_BITS + 1;
    localparam int TIME_BITS  = 63;
    localparam int GAP_BITS   = 64;
    localparam int DELAY_BITS = 20;
    localparam int PROD_BITS  = 30;
    localparam int US_PER_MS  = 1000;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [TIME_BITS-1:0]  now_us;
        logic [DELAY_BITS-1:0] delay_ms;
        logic [15:0]           tag;
    } tdq_request_t;

    typedef struct packed {
        logic [15:0]          fired_tag;
        logic                 fired;
        logic                 last;
        logic [GAP_BITS-1:0]  time_to_next;
        logic                 overflow;
        logic [5:0]           count;
    } tdq_result_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
        logic                 sub;
    } tdq_alu_req_t;

    // physical slot of a queue position counted from the head
    function automatic logic [ADDR_BITS-1:0] slot(input logic [ADDR_BITS-1:0] base,
                                                  input logic [CNT_BITS-1:0] ofs);
        logic [SLOT_BITS-1:0] s;
        s = SLOT_BITS'(base) + SLOT_BITS'(ofs);
        if (s >= SLOT_BITS'(QUEUE_DEPTH))
        begin
            s = s - SLOT_BITS'(QUEUE_DEPTH);
        end
        return s[ADDR_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
//
// A request is taken when start is high and busy is low; busy stays high
// until the last result of that request has been produced. Results appear on
// result for one cycle with done high and cannot be held off. The entry store
// is a single memory with registered read, so every entry visited takes a read
// state and then an evaluate state on the shared adder. A schedule adds the
// deadline, moves back each entry with a later deadline, places the new entry
// and reports; when the queue is full the request overflows and goes straight
// to the report. A run scans the expired entries from the head and emits one
// result per expired entry, or a single report when none expire.
// Each result is held in the output register before it leaves on result.
module sorted_deadline_timer_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  tdq_pkg::tdq_request_t   request,
    output logic                    done,
    output tdq_pkg::tdq_result_t    result
);

    tdq_pkg::tdq_alu_req_t          alu_req;
    logic [tdq_pkg::GAP_BITS-1:0]   alu_sum;
    logic                           res_valid;
    tdq_pkg::tdq_result_t           res;
    logic                           done_reg;
    tdq_pkg::tdq_result_t           result_reg;

    tdq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .alu_req   (alu_req),
        .alu_sum   (alu_sum),
        .res_valid (res_valid),
        .res       (res)
    );

    tdq_alu u_alu (
        .alu_req (alu_req),
        .sum     (alu_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/tdq_alu.sv
// shared 64-bit add and subtract unit for deadlines and time gaps
module tdq_alu (
    input  tdq_pkg::tdq_alu_req_t           alu_req,
    output logic [tdq_pkg::GAP_BITS-1:0]    sum
);

    assign sum = tdq_pkg::GAP_BITS'(alu_req.a)
               + (tdq_pkg::GAP_BITS'(alu_req.b) ^ {tdq_pkg::GAP_BITS{alu_req.sub}})
               + tdq_pkg::GAP_BITS'(alu_req.sub);

endmodule

FILE: rtl/core/tdq_seq.sv
// sequencer and entry store of the timer queue
`include "assert_macros.svh"

module tdq_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  tdq_pkg::tdq_request_t               request,
    output tdq_pkg::tdq_alu_req_t               alu_req,
    input  logic [tdq_pkg::GAP_BITS-1:0]        alu_sum,
    output logic                                res_valid,
    output tdq_pkg::tdq_result_t                res
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_ADD      = 11'b000_0000_0010,
        ST_SHIFT_RD = 11'b000_0000_0100,
        ST_SHIFT_EV = 11'b000_0000_1000,
        ST_PLACE    = 11'b000_0001_0000,
        ST_SCAN_RD  = 11'b000_0010_0000,
        ST_SCAN_EV  = 11'b000_0100_0000,
        ST_GAP      = 11'b000_1000_0000,
        ST_REPORT   = 11'b001_0000_0000,
        ST_EMIT_RD  = 11'b010_0000_0000,
        ST_EMIT_EV  = 11'b100_0000_0000
    } tdq_state_t;

    typedef struct packed {
        logic [tdq_pkg::TIME_BITS-1:0] dl;
        logic [tdq_pkg::TAG_BITS-1:0]  tag;
    } tdq_entry_t;

    tdq_state_t                         state_reg, state_next;
    logic [tdq_pkg::CNT_BITS-1:0]       occ_reg, occ_next;
    logic [tdq_pkg::ADDR_BITS-1:0]      head_reg, head_next;
    logic [tdq_pkg::CNT_BITS-1:0]       idx_reg, idx_next;
    logic [tdq_pkg::CNT_BITS-1:0]       n_reg, n_next;
    logic                               op_reg, op_next;
    logic [tdq_pkg::TIME_BITS-1:0]      now_reg, now_next;
    logic [tdq_pkg::PROD_BITS-1:0]      prod_reg, prod_next;
    logic [tdq_pkg::TAG_BITS-1:0]       tag_reg, tag_next;
    logic [tdq_pkg::TIME_BITS-1:0]      when_reg, when_next;
    logic [tdq_pkg::TIME_BITS-1:0]      head_dl_reg, head_dl_next;
    logic [tdq_pkg::GAP_BITS-1:0]       gap_reg, gap_next;
    logic                               ovf_reg, ovf_next;

    tdq_entry_t                         mem [tdq_pkg::QUEUE_DEPTH];
    tdq_entry_t                         rd_q;
    tdq_entry_t                         wr_data;
    logic [tdq_pkg::ADDR_BITS-1:0]      rd_addr;
    logic [tdq_pkg::ADDR_BITS-1:0]      wr_addr;
    logic                               we;

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        head_next    = head_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        op_next      = op_reg;
        now_next     = now_reg;
        prod_next    = prod_reg;
        tag_next     = tag_reg;
        when_next    = when_reg;
        head_dl_next = head_dl_reg;
        gap_next     = gap_reg;
        ovf_next     = ovf_reg;

        rd_addr = tdq_pkg::slot(head_reg, idx_reg);
        we      = 1'b0;
        wr_addr = tdq_pkg::slot(head_reg, idx_reg);
        wr_data = '{dl: when_reg, tag: tag_reg};

        alu_req = '{a: now_reg, b: tdq_pkg::TIME_BITS'(prod_reg), sub: 1'b0};

        res_valid        = 1'b0;
        res.fired_tag    = '0;
        res.fired        = 1'b0;
        res.last         = 1'b1;
        res.time_to_next = gap_reg;
        res.overflow     = ovf_reg;
        res.count        = 6'(occ_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = request.op;
                    now_next  = request.now_us;
                    prod_next = tdq_pkg::PROD_BITS'(request.delay_ms)
                              * tdq_pkg::PROD_BITS'(tdq_pkg::US_PER_MS);
                    tag_next  = tdq_pkg::TAG_BITS'(request.tag);
                    ovf_next  = 1'b0;
                    idx_next  = '0;
                    n_next    = '0;
                    if (request.op == tdq_pkg::OP_RUN)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else if (occ_reg == tdq_pkg::CNT_BITS'(tdq_pkg::QUEUE_DEPTH))
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_GAP;
                    end
                    else
                    begin
                        idx_next   = occ_reg;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                // deadline, saturated to the time range
                when_next  = alu_sum[tdq_pkg::GAP_BITS-1] ? tdq_pkg::TIME_MAX
                                                           : alu_sum[tdq_pkg::TIME_BITS-1:0];
                state_next = ST_SHIFT_RD;
            end
            ST_SHIFT_RD:
            begin
                rd_addr = tdq_pkg::slot(head_reg, idx_reg - tdq_pkg::CNT_BITS'(1));
                if (idx_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_SHIFT_EV;
                end
            end
            ST_SHIFT_EV:
            begin
                alu_req = '{a: when_reg, b: rd_q.dl, sub: 1'b1};
                // entry later than the new deadline moves one place back
                if (alu_sum[tdq_pkg::GAP_BITS-1])
                begin
                    we         = 1'b1;
                    wr_data    = rd_q;
                    idx_next   = idx_reg - tdq_pkg::CNT_BITS'(1);
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                we       = 1'b1;
                occ_next = occ_reg + tdq_pkg::CNT_BITS'(1);
                if (idx_reg == '0)
                begin
                    head_dl_next = when_reg;
                end
                state_next = ST_GAP;
            end
            ST_SCAN_RD:
            begin
                if (idx_reg == occ_reg)
                begin
                    n_next     = idx_reg;
                    occ_next   = '0;
                    state_next = ST_GAP;
                end
                else
                begin
                    state_next = ST_SCAN_EV;
                end
            end
            ST_SCAN_EV:
            begin
                alu_req = '{a: rd_q.dl, b: now_reg, sub: 1'b1};
                if (alu_sum[tdq_pkg::GAP_BITS-1])
                begin
                    idx_next   = idx_reg + tdq_pkg::CNT_BITS'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    n_next       = idx_reg;
                    occ_next     = occ_reg - idx_reg;
                    head_dl_next = rd_q.dl;
                    state_next   = ST_GAP;
                end
            end
            ST_GAP:
            begin
                alu_req  = '{a: head_dl_reg, b: now_reg, sub: 1'b1};
                gap_next = (occ_reg == '0) ? '0 : alu_sum;
                idx_next = '0;
                if (op_reg == tdq_pkg::OP_RUN && n_reg != '0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                res_valid  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_EV;
            end
            ST_EMIT_EV:
            begin
                res_valid     = 1'b1;
                res.fired     = 1'b1;
                res.fired_tag = 16'(rd_q.tag);
                res.last      = (idx_reg + tdq_pkg::CNT_BITS'(1)) == n_reg;
                if (res.last)
                begin
                    head_next  = tdq_pkg::slot(head_reg, n_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + tdq_pkg::CNT_BITS'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        op_reg      <= op_next;
        now_reg     <= now_next;
        prod_reg    <= prod_next;
        tag_reg     <= tag_next;
        when_reg    <= when_next;
        head_dl_reg <= head_dl_next;
        gap_reg     <= gap_next;
        ovf_reg     <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    `TDQ_ASSERT(a_occ_in_range, clk, rst_n, occ_reg <= tdq_pkg::CNT_BITS'(tdq_pkg::QUEUE_DEPTH), "occupancy beyond depth")
    `TDQ_ASSERT_NEXT(a_last_ends_item, clk, rst_n, res_valid && res.last, !res_valid, "result after last")
    `TDQ_ASSERT(a_ovf_when_full, clk, rst_n, !(res_valid && res.overflow) || occ_reg == tdq_pkg::CNT_BITS'(tdq_pkg::QUEUE_DEPTH), "overflow with room left")
    `TDQ_ASSERT(a_idle_after_result, clk, rst_n, !$fell(busy) || $past(res_valid), "request ended without result")

endmodule
